[rtl/tcw_pkg.sv]
// Shared types and constants for the text console writer.
`timescale 1ns / 1ps

package tcw_pkg;

    // Operation codes
    localparam logic [2:0] OP_PUT_CURSOR = 3'd0;
    localparam logic [2:0] OP_PUT_AT     = 3'd1;
    localparam logic [2:0] OP_SET_CURSOR = 3'd2;
    localparam logic [2:0] OP_CLEAR      = 3'd3;
    localparam logic [2:0] OP_READ       = 3'd4;

    localparam logic [7:0] NEWLINE_CODE      = 8'd10;
    localparam logic [7:0] BLANK_CODE        = 8'd32;
    localparam logic [7:0] DEFAULT_ATTR_INIT = 8'd15;

    localparam int CURSOR_W = 11;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_EXEC   = 5'b00010,
        ST_SCROLL = 5'b00100,
        ST_CLEAR  = 5'b01000,
        ST_RESP   = 5'b10000
    } state_t;

endpackage

[rtl/text_console_writer.sv]
// Text console writer: cell store, cursor, scroll and clear sequencer.
// Flow: the execute state, a scroll or clear sweep where needed, then the
// response state, where the result is registered. Items are taken only in
// idle or as a result loads. A scroll does one copy read and one write per
// cycle, blanking the last row; a clear does one blank write per cycle.
// Reset: cursor to cell 0, default_attr to 15; the cell store is not cleared.
`timescale 1ns / 1ps

module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_wdata,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [2:0]          opcode,
    input  logic [7:0]          char_code,
    input  logic [6:0]          column,
    input  logic [4:0]          row,
    input  logic [7:0]          attribute,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [CURSOR_W-1:0] cursor_cell,
    output logic [7:0]          cell_char,
    output logic [7:0]          cell_attr
);

    localparam int CELLS    = COLUMNS * ROWS;
    localparam int COPY_CNT = CELLS - COLUMNS;
    localparam int COL_W    = $clog2(COLUMNS);
    localparam int ROW_W    = $clog2(ROWS);
    localparam int ADDR_W   = $clog2(CELLS);
    localparam int CNT_W    = $clog2(CELLS + 1);

    localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

    // Cell store: {attribute, character}
    logic [15:0] screen_mem [CELLS];
    logic [15:0] rd_data_reg;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [15:0]       mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    state_t            state_reg, state_next;
    logic [7:0]        default_attr_reg;
    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [CNT_W-1:0]  sweep_reg, sweep_next;

    logic [2:0]        op_reg;
    logic [7:0]        char_reg;
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [7:0]        attr_reg;

    logic                out_valid_reg, out_valid_next;
    logic [CURSOR_W-1:0] cursor_cell_reg;
    logic [7:0]          cell_char_reg;
    logic [7:0]          cell_attr_reg;

    logic              in_accept;
    logic              out_load;
    logic [COL_W-1:0]  col_sat;
    logic [ROW_W-1:0]  row_sat;
    logic [ROW_W-1:0]  tgt_row;
    logic [COL_W-1:0]  tgt_col;
    logic [ADDR_W-1:0] tgt_addr;
    logic [ADDR_W-1:0] cur_addr;
    logic              wrap;
    logic [7:0]        put_attr;
    logic [15:0]       blank_cell;

    assign out_load  = (state_reg == ST_RESP) && (!out_valid_reg || !out_stall);
    assign in_stall  = !((state_reg == ST_IDLE) || out_load);
    assign in_accept = in_valid && !in_stall;

    assign col_sat = (32'(column) >= COLUMNS) ? COL_LAST : COL_W'(column);
    assign row_sat = (32'(row) >= ROWS) ? ROW_LAST : ROW_W'(row);

    assign tgt_row  = (op_reg == OP_PUT_CURSOR) ? cur_row_reg : row_reg;
    assign tgt_col  = (op_reg == OP_PUT_CURSOR) ? cur_col_reg : col_reg;
    assign tgt_addr = ADDR_W'(tgt_row) * ADDR_W'(COLUMNS) + ADDR_W'(tgt_col);
    assign cur_addr = ADDR_W'(cur_row_reg) * ADDR_W'(COLUMNS) + ADDR_W'(cur_col_reg);
    assign wrap     = (char_reg == NEWLINE_CODE) || (tgt_col == COL_LAST);
    assign put_attr   = (attr_reg == 8'd0) ? default_attr_reg : attr_reg;
    assign blank_cell = {default_attr_reg, BLANK_CODE};

    always_comb
    begin
        state_next   = state_reg;
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        sweep_next   = sweep_reg;
        mem_we       = 1'b0;
        mem_waddr    = tgt_addr;
        mem_wdata    = {put_attr, char_reg};
        mem_re       = 1'b0;
        mem_raddr    = tgt_addr;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_RESP;
                case (op_reg)
                    OP_PUT_CURSOR, OP_PUT_AT:
                    begin
                        mem_we = (char_reg != NEWLINE_CODE);
                        if (!wrap)
                        begin
                            cur_row_next = tgt_row;
                            cur_col_next = tgt_col + COL_W'(1);
                        end
                        else if (tgt_row == ROW_LAST)
                        begin
                            cur_row_next = ROW_LAST;
                            cur_col_next = '0;
                            sweep_next   = '0;
                            state_next   = ST_SCROLL;
                        end
                        else
                        begin
                            cur_row_next = tgt_row + ROW_W'(1);
                            cur_col_next = '0;
                        end
                    end
                    OP_SET_CURSOR:
                    begin
                        cur_row_next = row_reg;
                        cur_col_next = col_reg;
                    end
                    OP_CLEAR:
                    begin
                        cur_row_next = '0;
                        cur_col_next = '0;
                        sweep_next   = '0;
                        state_next   = ST_CLEAR;
                    end
                    OP_READ:
                    begin
                        mem_re = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_SCROLL:
            begin
                // read one row ahead, write back the cell read last cycle
                mem_re    = (32'(sweep_reg) < COPY_CNT);
                mem_raddr = ADDR_W'(sweep_reg + CNT_W'(COLUMNS));
                mem_we    = (sweep_reg != '0);
                mem_waddr = ADDR_W'(sweep_reg - CNT_W'(1));
                mem_wdata = (32'(sweep_reg) <= COPY_CNT) ? rd_data_reg : blank_cell;
                sweep_next = sweep_reg + CNT_W'(1);
                if (32'(sweep_reg) == CELLS)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_CLEAR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = ADDR_W'(sweep_reg);
                mem_wdata  = blank_cell;
                sweep_next = sweep_reg + CNT_W'(1);
                if (32'(sweep_reg) == CELLS - 1)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (out_load)
                begin
                    state_next = in_accept ? ST_EXEC : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            screen_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= screen_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            default_attr_reg <= DEFAULT_ATTR_INIT;
            cur_row_reg      <= '0;
            cur_col_reg      <= '0;
            sweep_reg        <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            sweep_reg     <= sweep_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                default_attr_reg <= cfg_wdata;
            end
        end
    end

    // Item and result payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg   <= opcode;
            char_reg <= char_code;
            col_reg  <= col_sat;
            row_reg  <= row_sat;
            attr_reg <= attribute;
        end
        if (out_load)
        begin
            cursor_cell_reg <= CURSOR_W'(cur_addr);
            if (op_reg == OP_READ)
            begin
                cell_char_reg <= rd_data_reg[7:0];
                cell_attr_reg <= rd_data_reg[15:8];
            end
            else
            begin
                cell_char_reg <= 8'd0;
                cell_attr_reg <= 8'd0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign cursor_cell = cursor_cell_reg;
    assign cell_char   = cell_char_reg;
    assign cell_attr   = cell_attr_reg;

`ifndef SYNTH
    a_accept_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |-> (state_reg == ST_IDLE || state_reg == ST_RESP))
        else $error("item taken while a sweep or execute step is in progress");

    a_load_gives_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid)
        else $error("result loaded but not presented");

    a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(cur_row_reg) < ROWS) && (32'(cur_col_reg) < COLUMNS))
        else $error("cursor outside the screen");

    a_sweep_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCROLL || state_reg == ST_CLEAR) |-> (32'(sweep_reg) <= CELLS))
        else $error("sweep counter ran past the cell store");
`endif

endmodule
